@@ hdl/tbpr_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types and constants of the tile background pixel renderer: field
// widths, video memory layout, opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package tbpr_pkg;

    // screen size in pixels
    localparam int unsigned SCREEN_WIDTH  = 160;
    localparam int unsigned SCREEN_HEIGHT = 144;

    // field widths
    localparam int unsigned VRAM_ADDR_W = 13;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SHADE_W     = 2;
    localparam int unsigned CFG_IDX_W   = 3;

    // video memory split into an even and an odd bank
    localparam int unsigned BANK_ADDR_W = VRAM_ADDR_W - 1;
    localparam int unsigned BANK_DEPTH  = 1 << BANK_ADDR_W;

    // video memory offsets (cpu address minus 0x8000)
    localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_BASE   = 13'h1800;
    localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_BASE  = 13'h1C00;
    localparam logic [VRAM_ADDR_W-1:0] SIGNED_BASE    = 13'h0800;
    localparam logic [BYTE_W-1:0]      SIGN_FLIP      = 8'h80;
    localparam logic [BYTE_W:0]        WINDOW_OFFSET  = 9'd7;

    // lcd control bit positions
    localparam int unsigned LCDC_ENABLE   = 7;
    localparam int unsigned LCDC_WIN_MAP  = 6;
    localparam int unsigned LCDC_WIN_EN   = 5;
    localparam int unsigned LCDC_TILE_SET = 4;
    localparam int unsigned LCDC_BG_MAP   = 3;
    localparam int unsigned LCDC_BG_EN    = 0;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE  = 3'd5;

    // configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] lcdc;
        logic [BYTE_W-1:0] scy;
        logic [BYTE_W-1:0] scx;
        logic [BYTE_W-1:0] wy;
        logic [BYTE_W-1:0] wx;
        logic [BYTE_W-1:0] bgp;
    } t_cfg;

endpackage

@@ hdl/tbpr_in_if.sv @@
// ----------------------------------------------------------------------------
// tbpr_in_if
// Input channel: video memory writes and pixel render requests.
// ----------------------------------------------------------------------------
interface tbpr_in_if;
    import tbpr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [VRAM_ADDR_W-1:0] vram_addr;
    logic [BYTE_W-1:0]      vram_data;
    logic [BYTE_W-1:0]      pixel_x;
    logic [BYTE_W-1:0]      scan_line;

    modport source (output valid, opcode, vram_addr, vram_data, pixel_x, scan_line,
                    input ready);
    modport sink   (input valid, opcode, vram_addr, vram_data, pixel_x, scan_line,
                    output ready);
endinterface

@@ hdl/tbpr_out_if.sv @@
// ----------------------------------------------------------------------------
// tbpr_out_if
// Output channel: one shade per rendered pixel.
// ----------------------------------------------------------------------------
interface tbpr_out_if;
    import tbpr_pkg::*;

    logic               valid;
    logic               ready;
    logic [SHADE_W-1:0] shade;
    logic               from_window;

    modport source (output valid, shade, from_window, input ready);
    modport sink   (input valid, shade, from_window, output ready);
endinterface

@@ hdl/tbpr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tbpr_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module tbpr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tbpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tbpr_pkg::BYTE_W-1:0]      i_cfg_data,
    output tbpr_pkg::t_cfg                   o_cfg
);
    import tbpr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LCD_CONTROL: n_cfg.lcdc = i_cfg_data;
                CFG_SCROLL_Y:    n_cfg.scy  = i_cfg_data;
                CFG_SCROLL_X:    n_cfg.scx  = i_cfg_data;
                CFG_WINDOW_Y:    n_cfg.wy   = i_cfg_data;
                CFG_WINDOW_X:    n_cfg.wx   = i_cfg_data;
                CFG_BG_PALETTE:  n_cfg.bgp  = i_cfg_data;
                default:         n_cfg      = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ hdl/tbpr_vram_bank.sv @@
// ----------------------------------------------------------------------------
// tbpr_vram_bank
// One half of the video memory: one write port and two read ports with
// registered read data that holds while its enable is low.
// ----------------------------------------------------------------------------
module tbpr_vram_bank (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [tbpr_pkg::BANK_ADDR_W-1:0] i_waddr,
    input  logic [tbpr_pkg::BYTE_W-1:0]      i_wdata,
    input  logic                             i_re_a,
    input  logic [tbpr_pkg::BANK_ADDR_W-1:0] i_addr_a,
    output logic [tbpr_pkg::BYTE_W-1:0]      o_rd_a,
    input  logic                             i_re_b,
    input  logic [tbpr_pkg::BANK_ADDR_W-1:0] i_addr_b,
    output logic [tbpr_pkg::BYTE_W-1:0]      o_rd_b
);
    import tbpr_pkg::*;

    logic [BYTE_W-1:0] r_mem [BANK_DEPTH];
    logic [BYTE_W-1:0] r_rd_a;
    logic [BYTE_W-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rd_a <= r_mem[i_addr_a];
        end
        if (i_re_b) begin
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;
endmodule

@@ hdl/tile_background_pixel_render.sv @@
// ----------------------------------------------------------------------------
// tile_background_pixel_render
// Background and window pixel renderer over an 8 KB tile video memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  i_in      in         valid / ready      opcode, vram_addr, vram_data,
//                                          pixel_x, scan_line
//  o_out     out        valid / ready      shade, from_window
//  i_cfg_*   in         write enable only  index, data (8 bits)
//
//  One item per cycle while o_out is not stalled. After accept, a render
//  result passes the coordinate stage, map read, tile read and shade register.
//  The rate is set by the video memory: two banks (even and odd bytes), each
//  with one write and two read ports, so map and tile bytes are read per cycle.
//  Writes land in memory as they leave stage 1; writes give no result.
//  Reset clears the valid bits and the configuration; no memory clearing.
//  A stall on o_out backs up stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tile_background_pixel_render (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tbpr_in_if.sink                        i_in,
    tbpr_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [tbpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbpr_pkg::BYTE_W-1:0]    i_cfg_data
);
    import tbpr_pkg::*;

    t_cfg cfg;

    // stage handshake
    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 0 coordinate math
    logic                   en0;
    logic                   win0;
    logic [BYTE_W:0]        x_plus7;
    logic [BYTE_W-1:0]      px0;
    logic [BYTE_W-1:0]      py0;
    logic [VRAM_ADDR_W-1:0] map_base0;
    logic [VRAM_ADDR_W-1:0] map_addr0;

    // stage 1 registers
    logic                   r_op1;
    logic [VRAM_ADDR_W-1:0] r_addr1;
    logic [BYTE_W-1:0]      r_wdata1;
    logic [2:0]             r_row1;
    logic [2:0]             r_col1;
    logic                   r_en1;
    logic                   r_win1;

    // stage 2 registers
    logic                   r_sel2;
    logic [2:0]             r_row2;
    logic [2:0]             r_col2;
    logic                   r_en2;
    logic                   r_win2;
    logic [BYTE_W-1:0]      tile_id;
    logic [VRAM_ADDR_W-1:0] tile_base;
    logic [VRAM_ADDR_W-1:0] tile_addr;

    // stage 3 registers
    logic [2:0]             r_col3;
    logic                   r_en3;
    logic                   r_win3;
    logic [BYTE_W-1:0]      lo_byte;
    logic [BYTE_W-1:0]      hi_byte;
    logic [2:0]             bit_pos;
    logic [1:0]             color_idx;

    // output register
    logic [SHADE_W-1:0]     r_shade4;
    logic                   r_win4;

    // memory ports
    logic                   mem_we;
    logic                   we_even, we_odd;
    logic [BYTE_W-1:0]      rd_a_even, rd_a_odd;

    tbpr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // backpressure chain
    assign rdy4 = !r_v4 || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_in.ready = rdy1;

    // window test and plane coordinates
    always_comb begin
        en0 = cfg.lcdc[LCDC_ENABLE] && cfg.lcdc[LCDC_BG_EN]
              && ({24'd0, i_in.pixel_x} < SCREEN_WIDTH)
              && ({24'd0, i_in.scan_line} < SCREEN_HEIGHT);
        x_plus7 = {1'b0, i_in.pixel_x} + WINDOW_OFFSET;
        win0 = cfg.lcdc[LCDC_WIN_EN]
               && (i_in.scan_line >= cfg.wy)
               && (x_plus7 >= {1'b0, cfg.wx});
        if (win0) begin
            px0       = x_plus7[BYTE_W-1:0] - cfg.wx;
            py0       = i_in.scan_line - cfg.wy;
            map_base0 = cfg.lcdc[LCDC_WIN_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
        end else begin
            px0       = i_in.pixel_x + cfg.scx;
            py0       = i_in.scan_line + cfg.scy;
            map_base0 = cfg.lcdc[LCDC_BG_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
        end
        map_addr0 = map_base0 + {3'd0, py0[7:3], px0[7:3]};
    end

    // stage 1: write address or map address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_op1    <= i_in.opcode;
            r_addr1  <= (i_in.opcode == OP_RENDER) ? map_addr0 : i_in.vram_addr;
            r_wdata1 <= i_in.vram_data;
            r_row1   <= py0[2:0];
            r_col1   <= px0[2:0];
            r_en1    <= en0;
            r_win1   <= win0;
        end
    end

    // memory write as a write transaction leaves stage 1
    assign mem_we  = rdy2 && r_v1 && (r_op1 == OP_WRITE);
    assign we_even = mem_we && !r_addr1[0];
    assign we_odd  = mem_we && r_addr1[0];

    // stage 2: tile id from the map read; writes drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && (r_op1 == OP_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_sel2 <= r_addr1[0];
            r_row2 <= r_row1;
            r_col2 <= r_col1;
            r_en2  <= r_en1;
            r_win2 <= r_win1;
        end
    end

    // tile data address, unsigned or signed tile numbering
    always_comb begin
        tile_id = r_sel2 ? rd_a_odd : rd_a_even;
        if (cfg.lcdc[LCDC_TILE_SET]) begin
            tile_base = {1'b0, tile_id, 4'd0};
        end else begin
            tile_base = SIGNED_BASE + {1'b0, tile_id ^ SIGN_FLIP, 4'd0};
        end
        tile_addr = tile_base + {9'd0, r_row2, 1'b0};
    end

    // stage 3: low and high bit planes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_col3 <= r_col2;
            r_en3  <= r_en2;
            r_win3 <= r_win2;
        end
    end

    // color index from the two bit planes
    always_comb begin
        bit_pos   = 3'd7 - r_col3;
        color_idx = {hi_byte[bit_pos], lo_byte[bit_pos]};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_shade4 <= r_en3 ? cfg.bgp[{color_idx, 1'b0} +: SHADE_W] : '0;
            r_win4   <= r_en3 && r_win3;
        end
    end

    assign o_out.valid       = r_v4;
    assign o_out.shade       = r_shade4;
    assign o_out.from_window = r_win4;

    // even bytes: map reads and low planes
    tbpr_vram_bank u_bank_even (
        .i_clk    (i_clk),
        .i_we     (we_even),
        .i_waddr  (r_addr1[VRAM_ADDR_W-1:1]),
        .i_wdata  (r_wdata1),
        .i_re_a   (rdy2),
        .i_addr_a (r_addr1[VRAM_ADDR_W-1:1]),
        .o_rd_a   (rd_a_even),
        .i_re_b   (rdy3),
        .i_addr_b (tile_addr[VRAM_ADDR_W-1:1]),
        .o_rd_b   (lo_byte)
    );

    // odd bytes: map reads and high planes
    tbpr_vram_bank u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (we_odd),
        .i_waddr  (r_addr1[VRAM_ADDR_W-1:1]),
        .i_wdata  (r_wdata1),
        .i_re_a   (rdy2),
        .i_addr_a (r_addr1[VRAM_ADDR_W-1:1]),
        .o_rd_a   (rd_a_odd),
        .i_re_b   (rdy3),
        .i_addr_b (tile_addr[VRAM_ADDR_W-1:1]),
        .o_rd_b   (hi_byte)
    );

    // a stalled stage 1 keeps its transaction
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !rdy2 |=> r_v1 && $stable(r_addr1) && $stable(r_op1))
        else $error("stage 1 transaction lost under stall");

    // tile planes hold while stage 3 is stalled
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !rdy4 |=> r_v3 && $stable(lo_byte) && $stable(hi_byte))
        else $error("tile data changed under stall");

    // a full pipeline with a stalled output refuses input
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && !o_out.ready |-> !i_in.ready)
        else $error("input accepted into a full pipeline");

    // a write transaction never reaches stage 2
    a_write_only_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> !r_v2 || $past(r_v2 && !rdy3))
        else $error("write transaction reached stage 2");
endmodule
